FILE: design/tick_sorted_event_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick sorted event queue
// Concurrent checks on clock, quiet during reset; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TICK_SORTED_EVENT_QUEUE_MACROS_SVH
`define TICK_SORTED_EVENT_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TSEQ_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define TSEQ_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define TSEQ_ASSERT_NOW(lbl, pre, post, msg)
`define TSEQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: design/tseq_pkg.sv
// ----------------------------------------------------------------------------
// tseq_pkg
// Shared types and codes of the tick sorted event queue.
// ----------------------------------------------------------------------------
`default_nettype none
package tseq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FLUSH  = 2'd1,
      OP_POP    = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   // one stored event
   typedef struct packed {
      logic [31:0] tick;
      logic [7:0]  port;
      logic [7:0]  status;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [15:0] extra_param;
   } entry_type;

   typedef struct packed {
      opcode_type opcode;
      entry_type  ev;
   } cmd_type;

   typedef struct packed {
      logic        has_event;
      entry_type   ev;
      logic [8:0]  op_count;
      logic [31:0] tail_tick;
      logic        queue_empty;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } emit_type;

   localparam int unsigned EntryWidth = $bits(entry_type);
   localparam int unsigned CountMax   = 511;

endpackage
`default_nettype wire

FILE: design/tseq_ram.sv
// ----------------------------------------------------------------------------
// tseq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tseq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: design/tseq_core.sv
// ----------------------------------------------------------------------------
// tseq_core
// Sequencer over the ring-ordered event store: insert shift, flush scan, pop, clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tick_sorted_event_queue_macros.svh"
module tseq_core #(
   parameter int unsigned DEPTH   = 256,
   parameter int unsigned POP_MAX = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire tseq_pkg::cmd_type cmd,
   input  wire logic              can_emit,
   output tseq_pkg::emit_type     emit
);
   import tseq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = $clog2(POP_MAX + 1);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_INS      = 8'b0000_0010,
      S_INS_PUT  = 8'b0000_0100,
      S_FLU      = 8'b0000_1000,
      S_POP_HEAD = 8'b0001_0000,
      S_POP_NEXT = 8'b0010_0000,
      S_POP_EMIT = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic [PW-1:0] popcnt_ff, popcnt_in;
   logic [31:0]   tail_ff, tail_in;
   logic [31:0]   lim_ff, lim_in;
   entry_type     new_ff, new_in;
   entry_type     cur_ff, cur_in;
   entry_type     nxt_ff, nxt_in;
   logic          nxt_due_ff, nxt_due_in;
   logic          pop_empty_ff, pop_empty_in;

   logic          rd_en, wr_en;
   logic [CW-1:0] rd_pos, wr_pos;
   entry_type     wr_data, rd_data;
   logic [EntryWidth-1:0] rd_raw;

   // offset from head to ring address
   function automatic logic [AW-1:0] pos2addr(input logic [AW-1:0] h,
                                              input logic [CW-1:0] p);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(p);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [8:0] sat9(input logic [CW-1:0] v);
      return (32'(v) > CountMax) ? 9'(CountMax) : 9'(32'(v));
   endfunction

   tseq_ram #(.WIDTH(EntryWidth), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos2addr(head_ff, wr_pos)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos2addr(head_ff, rd_pos)),
      .rd_data (rd_raw)
   );
   assign rd_data   = entry_type'(rd_raw);
   assign cmd_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rcnt_in      = rcnt_ff;
      popcnt_in    = popcnt_ff;
      tail_in      = tail_ff;
      lim_in       = lim_ff;
      new_in       = new_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      nxt_due_in   = nxt_due_ff;
      pop_empty_in = pop_empty_ff;
      rd_en        = 1'b0;
      rd_pos       = '0;
      wr_en        = 1'b0;
      wr_pos       = cnt_ff;
      wr_data      = new_ff;
      emit         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               lim_in  = cmd.ev.tick;
               new_in  = cmd.ev;
               rcnt_in = '0;
               cnt_in  = fill_ff;
               rd_pos  = fill_ff - CW'(1);
               case (cmd.opcode)
                  OP_INSERT: begin
                     state_in = S_DONE;
                     if (fill_ff < CW'(DEPTH)) begin
                        rcnt_in = CW'(1);
                        fill_in = fill_ff + CW'(1);
                        if (fill_ff == '0 || cmd.ev.tick >= tail_ff) begin
                           tail_in = cmd.ev.tick;
                        end
                        if (fill_ff == '0) begin
                           state_in = S_INS_PUT;
                        end else begin
                           rd_en    = 1'b1;
                           state_in = S_INS;
                        end
                     end
                  end
                  OP_FLUSH: begin
                     if (fill_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_FLU;
                     end
                  end
                  OP_POP: begin
                     popcnt_in    = '0;
                     pop_empty_in = (fill_ff == '0) ||
                                    (32'(fill_ff) <= 32'(POP_MAX) &&
                                     tail_ff <= cmd.ev.tick);
                     if (fill_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_pos   = '0;
                        state_in = S_POP_HEAD;
                     end
                  end
                  default: begin
                     fill_in  = '0;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // rd_data holds the entry at offset cnt-1
         S_INS: begin
            if (rd_data.tick > lim_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               cnt_in  = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  rd_en  = 1'b1;
                  rd_pos = cnt_ff - CW'(2);
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end

         // suffix at or above the limit is dropped; order keeps it contiguous
         S_FLU: begin
            if (rd_data.tick >= lim_ff) begin
               rcnt_in = rcnt_ff + CW'(1);
               cnt_in  = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  fill_in  = '0;
                  state_in = S_DONE;
               end else begin
                  rd_en  = 1'b1;
                  rd_pos = cnt_ff - CW'(2);
               end
            end else begin
               fill_in  = cnt_ff;
               tail_in  = rd_data.tick;
               state_in = S_DONE;
            end
         end

         S_POP_HEAD: begin
            if (rd_data.tick > lim_ff) begin
               state_in = S_DONE;
            end else begin
               cur_in    = rd_data;
               head_in   = pos2addr(head_ff, CW'(1));
               fill_in   = fill_ff - CW'(1);
               popcnt_in = popcnt_ff + PW'(1);
               if (fill_ff > CW'(1) &&
                   (PW+1)'(popcnt_ff) + (PW+1)'(1) < (PW+1)'(POP_MAX)) begin
                  rd_en    = 1'b1;
                  rd_pos   = CW'(1);
                  state_in = S_POP_NEXT;
               end else begin
                  nxt_due_in = 1'b0;
                  state_in   = S_POP_EMIT;
               end
            end
         end

         S_POP_NEXT: begin
            nxt_in     = rd_data;
            nxt_due_in = (rd_data.tick <= lim_ff);
            state_in   = S_POP_EMIT;
         end

         S_POP_EMIT: begin
            if (can_emit) begin
               emit.valid               = 1'b1;
               emit.res.has_event       = 1'b1;
               emit.res.ev              = cur_ff;
               emit.res.last            = !nxt_due_ff;
               emit.res.queue_empty     = pop_empty_ff;
               emit.res.tail_tick       = pop_empty_ff ? '0 : tail_ff;
               if (nxt_due_ff) begin
                  cur_in    = nxt_ff;
                  head_in   = pos2addr(head_ff, CW'(1));
                  fill_in   = fill_ff - CW'(1);
                  popcnt_in = popcnt_ff + PW'(1);
                  if (fill_ff > CW'(1) &&
                      (PW+1)'(popcnt_ff) + (PW+1)'(1) < (PW+1)'(POP_MAX)) begin
                     rd_en    = 1'b1;
                     rd_pos   = CW'(1);
                     state_in = S_POP_NEXT;
                  end else begin
                     nxt_due_in = 1'b0;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_DONE: begin
            if (can_emit) begin
               emit.valid           = 1'b1;
               emit.res.op_count    = sat9(rcnt_ff);
               emit.res.last        = 1'b1;
               emit.res.queue_empty = (fill_ff == '0);
               emit.res.tail_tick   = (fill_ff == '0) ? '0 : tail_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rcnt_ff      <= rcnt_in;
      popcnt_ff    <= popcnt_in;
      tail_ff      <= tail_in;
      lim_ff       <= lim_in;
      new_ff       <= new_in;
      cur_ff       <= cur_in;
      nxt_ff       <= nxt_in;
      nxt_due_ff   <= nxt_due_in;
      pop_empty_ff <= pop_empty_in;
   end

   `TSEQ_ASSERT_NOW(a_fill_range, 1'b1, 32'(fill_ff) <= 32'(DEPTH), "fill beyond depth")
   `TSEQ_ASSERT_NOW(a_emit_slot, emit.valid, can_emit, "result issued into busy register")
   `TSEQ_ASSERT_NOW(a_scan_pos, (state_ff == S_INS) || (state_ff == S_FLU), cnt_ff != '0,
                    "scan offset underflow")
   `TSEQ_ASSERT_NEXT(a_pop_bound, (state_ff == S_POP_EMIT) && emit.valid && !emit.res.last,
                     32'(popcnt_ff) <= 32'(POP_MAX), "pop run too long")
endmodule
`default_nettype wire

FILE: design/tick_sorted_event_queue.sv
// ----------------------------------------------------------------------------
// tick_sorted_event_queue
// Fixed-depth MIDI event queue kept in ascending tick order in one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser opcode, tdata event/limit
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser has_event, tdata result, tlast
//
//  Events live in a ring in one RAM (registered read); no shifting for
//  pop, which only advances the head. Insert: k entries with a later tick
//  are moved behind the new one (at most DEPTH - 1); refused when full.
//  Flush: r entries removed (scan from the tail). Pop: one word per due
//  entry, the run ended by the POP_MAX cap or the last due entry; one word
//  when nothing is due. Clear, and flush or pop on empty: one result word.
//  One command at a time; req_tready is low while busy.
//  Reset (synchronous) empties the queue at once, no RAM clearing pass.
//  A stalled rsp holds the sequencer; a new request is taken while the
//  last word of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module tick_sorted_event_queue #(
   parameter int unsigned DEPTH   = 256,
   parameter int unsigned POP_MAX = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode[1:0]
   input  wire logic [1:0]   req_tuser,
   // tick[31:0] port[39:32] status[47:40] data_one[55:48] data_two[63:56]
   // extra_param[79:64]
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // has_event[0]
   output logic              rsp_tuser,
   // out_tick[31:0] out_port[39:32] out_status[47:40] out_data_one[55:48]
   // out_data_two[63:56] out_param[79:64] op_count[88:80] tail_tick[120:89]
   // queue_empty[121] zero[127:122]
   output logic [127:0]      rsp_tdata,
   output logic              rsp_tlast
);
   import tseq_pkg::*;

   cmd_type    cmd;
   emit_type   emit;
   logic       can_emit;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign cmd.opcode         = opcode_type'(req_tuser);
   assign cmd.ev.tick        = req_tdata[31:0];
   assign cmd.ev.port        = req_tdata[39:32];
   assign cmd.ev.status      = req_tdata[47:40];
   assign cmd.ev.data_one    = req_tdata[55:48];
   assign cmd.ev.data_two    = req_tdata[63:56];
   assign cmd.ev.extra_param = req_tdata[79:64];

   // output register free, or emptied this cycle
   assign can_emit = !rsp_valid_ff || rsp_tready;

   tseq_core #(.DEPTH(DEPTH), .POP_MAX(POP_MAX)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd),
      .can_emit  (can_emit),
      .emit      (emit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit.res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.has_event;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {6'd0, rsp_ff.queue_empty, rsp_ff.tail_tick, rsp_ff.op_count,
                        rsp_ff.ev.extra_param, rsp_ff.ev.data_two, rsp_ff.ev.data_one,
                        rsp_ff.ev.status, rsp_ff.ev.port, rsp_ff.ev.tick};
endmodule
`default_nettype wire
